// ===== rtl/cfpp_pkg.sv =====
package cfpp_pkg;

	localparam int unsigned DEF_MAX_PAYLOAD = 2048;
	localparam logic [7:0] DEF_VERSION = 8'h01;
	localparam logic [7:0] DEF_TYPE = 8'h01;

	localparam logic [7:0] SYNC0 = 8'hA5;
	localparam logic [7:0] SYNC1 = 8'h5A;
	localparam logic [7:0] SYNC2 = 8'hC3;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] IPV4_MIN = 16'd20;
	localparam logic [16:0] IPV6_HDR = 17'd40;
	localparam int unsigned IP_HDR_BYTES = 6;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_OK = 3'd1;
	localparam logic [2:0] EV_HDR = 3'd2;
	localparam logic [2:0] EV_LEN = 3'd3;
	localparam logic [2:0] EV_CRC = 3'd4;
	localparam logic [2:0] EV_IP = 3'd5;
	localparam logic [2:0] EV_DROP = 3'd6;

	localparam logic REG_VERSION = 1'b0;
	localparam logic REG_TYPE = 1'b1;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic payload_valid;
		logic [2:0] event_res;
		logic [15:0] frame_seq;
		logic [11:0] ip_length;
		logic [14:0] seq_gap;
		logic seq_reorder;
	} result_t;

	// CRC-16/CCITT-FALSE, one byte, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// ===== rtl/cfpp_core.sv =====
module cfpp_core #(
	parameter int unsigned MAX_PAYLOAD = 2048
) (
	input logic clk,
	input logic arst_n,
	input logic acc,
	input logic [7:0] rx_byte,
	input logic queue_full,
	input logic [7:0] exp_version,
	input logic [7:0] exp_type,
	output cfpp_pkg::result_t res
);
	import cfpp_pkg::*;

	localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
	localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

	typedef enum logic [3:0] {
		PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_VER, PH_TYPE, PH_SEQ_HI, PH_SEQ_LO,
		PH_LEN_HI, PH_LEN_LO, PH_DATA, PH_CRC_HI, PH_CRC_LO
	} phase_t;

	phase_t phase_q, phase_d;
	logic [15:0] seq_q, seq_d;
	logic [15:0] len_q, len_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0] crch_q, crch_d;
	logic [7:0] hdr_q [IP_HDR_BYTES];
	logic [7:0] hdr_d [IP_HDR_BYTES];
	logic [15:0] last_q, last_d;
	logic known_q, known_d;

	logic [15:0] crc_next;
	logic [CW-1:0] cnt_inc;
	logic [15:0] len_full;
	logic [3:0] ip_ver;
	logic [15:0] ip_hl;
	logic [15:0] tot4;
	logic [16:0] tot6;
	logic ip_ok;
	logic [11:0] ip_len;
	logic [15:0] delta;
	logic clr;
	logic [2:0] ev;

	assign crc_next = crc_byte(crc_q, rx_byte);
	assign cnt_inc = cnt_q + CW'(1);
	assign len_full = {len_q[15:8], rx_byte};
	assign delta = seq_q - (last_q + 16'd1);

	always_comb begin
		ip_ver = hdr_q[0][7:4];
		ip_hl = {10'd0, hdr_q[0][3:0], 2'b00};
		tot4 = {hdr_q[2], hdr_q[3]};
		tot6 = IPV6_HDR + {1'b0, hdr_q[4], hdr_q[5]};
		ip_ok = 1'b0;
		ip_len = '0;
		if (ip_ver == 4'd4) begin
			ip_ok = len_q >= IPV4_MIN && ip_hl >= IPV4_MIN && tot4 >= ip_hl && tot4 <= len_q;
			ip_len = tot4[11:0];
		end else if (ip_ver == 4'd6) begin
			ip_ok = len_q >= 16'(IPV6_HDR) && tot6 <= {1'b0, len_q};
			ip_len = tot6[11:0];
		end
	end

	always_comb begin
		phase_d = phase_q;
		seq_d = seq_q;
		len_d = len_q;
		cnt_d = cnt_q;
		crc_d = crc_q;
		crch_d = crch_q;
		hdr_d = hdr_q;
		last_d = last_q;
		known_d = known_q;
		res = '0;
		ev = EV_NONE;
		clr = 1'b0;
		unique case (phase_q)
			PH_SYNC0: begin
				if (rx_byte == SYNC0) phase_d = PH_SYNC1;
			end
			PH_SYNC1: begin
				if (rx_byte == SYNC1) phase_d = PH_SYNC2;
				else if (rx_byte != SYNC0) phase_d = PH_SYNC0;
			end
			PH_SYNC2: begin
				if (rx_byte == SYNC2) begin
					crc_d = CRC_SEED;
					phase_d = PH_VER;
				end else begin
					ev = EV_HDR;
					phase_d = (rx_byte == SYNC0) ? PH_SYNC1 : PH_SYNC0;
				end
			end
			PH_VER, PH_TYPE: begin
				if (rx_byte != ((phase_q == PH_VER) ? exp_version : exp_type)) begin
					ev = EV_HDR;
					clr = 1'b1;
				end else begin
					crc_d = crc_next;
					phase_d = (phase_q == PH_VER) ? PH_TYPE : PH_SEQ_HI;
				end
			end
			PH_SEQ_HI: begin
				seq_d = {rx_byte, 8'h00};
				crc_d = crc_next;
				phase_d = PH_SEQ_LO;
			end
			PH_SEQ_LO: begin
				seq_d = {seq_q[15:8], rx_byte};
				crc_d = crc_next;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d = {rx_byte, 8'h00};
				crc_d = crc_next;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_d = len_full;
				crc_d = crc_next;
				cnt_d = '0;
				if (len_full > MAX_LEN) begin
					ev = EV_LEN;
					clr = 1'b1;
				end else begin
					phase_d = (len_full != 16'd0) ? PH_DATA : PH_CRC_HI;
				end
			end
			PH_DATA: begin
				res.payload_byte = rx_byte;
				res.payload_valid = 1'b1;
				if (cnt_q < CW'(IP_HDR_BYTES)) hdr_d[cnt_q[2:0]] = rx_byte;
				cnt_d = cnt_inc;
				crc_d = crc_next;
				if (16'(cnt_inc) >= len_q) phase_d = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				crch_d = rx_byte;
				phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				clr = 1'b1;
				if ({crch_q, rx_byte} != crc_q) begin
					ev = EV_CRC;
				end else if (!ip_ok) begin
					ev = EV_IP;
				end else if (queue_full) begin
					ev = EV_DROP;
				end else begin
					ev = EV_OK;
					res.ip_length = ip_len;
					if (known_q) begin
						if (!delta[15]) res.seq_gap = delta[14:0];
						else res.seq_reorder = 1'b1;
					end
					last_d = seq_q;
					known_d = 1'b1;
				end
			end
			default: begin
				clr = 1'b1;
			end
		endcase
		if (clr) begin
			phase_d = PH_SYNC0;
			len_d = '0;
			cnt_d = '0;
			crc_d = CRC_SEED;
			crch_d = '0;
			for (int i = 0; i < IP_HDR_BYTES; i++) hdr_d[i] = '0;
		end
		res.event_res = ev;
		res.frame_seq = (ev != EV_NONE) ? seq_d : 16'd0;
		if (phase_d == PH_SYNC0 || phase_d == PH_SYNC1 || phase_d == PH_SYNC2) seq_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC0;
			seq_q <= '0;
			len_q <= '0;
			cnt_q <= '0;
			crc_q <= CRC_SEED;
			crch_q <= '0;
			for (int i = 0; i < IP_HDR_BYTES; i++) hdr_q[i] <= '0;
			last_q <= '0;
			known_q <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_d;
			seq_q <= seq_d;
			len_q <= len_d;
			cnt_q <= cnt_d;
			crc_q <= crc_d;
			crch_q <= crch_d;
			hdr_q <= hdr_d;
			last_q <= last_d;
			known_q <= known_d;
		end
	end

`ifndef SYNTHESIS
	a_crc_lo_ends: assert property (@(posedge clk) disable iff (!arst_n)
		acc && phase_q == PH_CRC_LO |=> phase_q == PH_SYNC0)
		else $error("frame did not end after last crc byte");
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		acc && res.event_res == EV_OK |=> known_q && last_q == $past(seq_q))
		else $error("accepted frame did not update last sequence");
	a_seq_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SYNC0 || phase_q == PH_SYNC1 || phase_q == PH_SYNC2 |-> seq_q == 16'd0)
		else $error("sequence not cleared while hunting");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> 16'(cnt_q) < len_q)
		else $error("payload count beyond frame length");
`endif

endmodule

// ===== rtl/cfpp_outq.sv =====
module cfpp_outq (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cfpp_pkg::result_t din,
	output logic full,
	output logic out_valid,
	input logic out_stall,
	output cfpp_pkg::result_t dout
);
	import cfpp_pkg::*;

	result_t ent_q [2];
	logic [1:0] cnt_q;
	logic rd_q;
	logic wr_q;
	logic pop;

	assign full = cnt_q == 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign pop = out_valid && !out_stall;
	assign dout = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue overflow");
	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> out_valid)
		else $error("full queue with no word shown");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("pushed word lost");
`endif

endmodule

// ===== rtl/crc_framed_ip_packet_parser.sv =====
// Each result word is registered in the output queue when its input byte is accepted.
// Throughput: one byte per cycle when not stalled; the parser state, CRC and checks update in one pass.
// A two-word output queue lets input continue while one result waits; input
// stalls only when both queue words are held.
// Reset (arst_n low, asynchronous): hunt for first sync byte, CRC seed FFFF,
// no known sequence, version and type registers back to 1, queue empty.
module crc_framed_ip_packet_parser #(
	parameter int unsigned MAX_PAYLOAD = cfpp_pkg::DEF_MAX_PAYLOAD
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] rx_byte,
	input logic queue_full,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] payload_byte,
	output logic payload_valid,
	output logic [2:0] event_res,
	output logic [15:0] frame_seq,
	output logic [11:0] ip_length,
	output logic [14:0] seq_gap,
	output logic seq_reorder,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [7:0] cfg_data
);
	import cfpp_pkg::*;

	logic [7:0] ver_q;
	logic [7:0] type_q;
	logic acc;
	logic full;
	result_t res;
	result_t dout;

	assign cfg_ready = 1'b1;
	assign in_stall = full;
	assign acc = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q <= DEF_VERSION;
			type_q <= DEF_TYPE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VERSION: ver_q <= cfg_data;
				REG_TYPE: type_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cfpp_core #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.rx_byte(rx_byte),
		.queue_full(queue_full),
		.exp_version(ver_q),
		.exp_type(type_q),
		.res(res)
	);

	cfpp_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(acc),
		.din(res),
		.full(full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dout(dout)
	);

	assign payload_byte = dout.payload_byte;
	assign payload_valid = dout.payload_valid;
	assign event_res = dout.event_res;
	assign frame_seq = dout.frame_seq;
	assign ip_length = dout.ip_length;
	assign seq_gap = dout.seq_gap;
	assign seq_reorder = dout.seq_reorder;

endmodule

// ===== tb/crc_framed_ip_packet_parser_test.sv =====
module crc_framed_ip_packet_parser_test;
	import cfpp_pkg::*;

	localparam int unsigned MAX_LEN = DEF_MAX_PAYLOAD;
	localparam logic [15:0] SEQ_HALF = 16'h8000;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 200;

	typedef enum logic [3:0] {
		ST_HUNT0, ST_HUNT1, ST_HUNT2, ST_VER, ST_TYPE, ST_SEQ_HI, ST_SEQ_LO,
		ST_LEN_HI, ST_LEN_LO, ST_DATA, ST_CRC_HI, ST_CRC_LO
	} parse_state_t;

	typedef enum {HD_V4_OK, HD_V4_BAD, HD_V6_OK, HD_V6_BAD, HD_JUNK} head_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic full;
	} rx_word_t;

	typedef logic [7:0] byte_q_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic queue_full = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic payload_valid;
	logic [2:0] event_res;
	logic [15:0] frame_seq;
	logic [11:0] ip_length;
	logic [14:0] seq_gap;
	logic seq_reorder;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_VERSION;
	logic [7:0] cfg_data = 8'h00;

	crc_framed_ip_packet_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.queue_full(queue_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_byte(payload_byte),
		.payload_valid(payload_valid),
		.event_res(event_res),
		.frame_seq(frame_seq),
		.ip_length(ip_length),
		.seq_gap(seq_gap),
		.seq_reorder(seq_reorder),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// parser shadow state
	parse_state_t ps = ST_HUNT0;
	logic [15:0] p_seq = 16'h0000;
	logic [15:0] p_len = 16'h0000;
	logic [15:0] p_count = 16'h0000;
	logic [15:0] p_crc = CRC_SEED;
	logic [7:0] p_crc_hi = 8'h00;
	logic [7:0] p_head[IP_HDR_BYTES];
	logic [15:0] acc_seq_last = 16'h0000;
	logic acc_seq_valid = 1'b0;
	logic [7:0] reg_version = DEF_VERSION;
	logic [7:0] reg_type = DEF_TYPE;

	rx_word_t rx_backlog[$];
	result_t expected_words[$];
	rx_word_t drv_word;
	result_t seen, want;

	int unsigned made = 0;
	int unsigned errors = 0;
	int unsigned n_checked = 0;
	int unsigned hold_left = 0;
	int unsigned quiet = 0;
	logic hold_req = 1'b0;
	logic send_pause = 1'b0;
	logic calm = 1'b0;
	logic [15:0] tx_seq = 16'h0000;

	initial begin
		foreach (p_head[i])
			p_head[i] = 8'h00;
	end

	function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] c;
		c = acc;
		for (int k = 7; k >= 0; k--) begin
			if (c[15] ^ data[k])
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic void clear_frame();
		ps = ST_HUNT0;
		p_len = 16'h0000;
		p_count = 16'h0000;
		p_crc = CRC_SEED;
		p_crc_hi = 8'h00;
		foreach (p_head[i])
			p_head[i] = 8'h00;
	endfunction

	function automatic int unsigned ip_len_of();
		int unsigned hl, total;
		if (p_len == 16'h0000)
			return 0;
		case (p_head[0][7:4])
			4'h4: begin
				if (p_len < IPV4_MIN)
					return 0;
				hl = p_head[0][3:0] * 4;
				total = {p_head[2], p_head[3]};
				return (hl >= IPV4_MIN && total >= hl && total <= p_len) ? total : 0;
			end
			4'h6: begin
				if (p_len < IPV6_HDR)
					return 0;
				total = IPV6_HDR + {p_head[4], p_head[5]};
				return (total <= p_len) ? total : 0;
			end
			default: return 0;
		endcase
	endfunction

	function automatic result_t parse_rx_byte(input logic [7:0] b, input logic full);
		result_t r;
		int unsigned iplen;
		logic [15:0] seq_delta;
		r = '0;
		case (ps)
			ST_HUNT0: begin
				if (b == SYNC0)
					ps = ST_HUNT1;
			end
			ST_HUNT1: begin
				if (b == SYNC1)
					ps = ST_HUNT2;
				else if (b != SYNC0)
					ps = ST_HUNT0;
			end
			ST_HUNT2: begin
				if (b == SYNC2) begin
					p_crc = CRC_SEED;
					ps = ST_VER;
				end else begin
					r.event_res = EV_HDR;
					ps = (b == SYNC0) ? ST_HUNT1 : ST_HUNT0;
				end
			end
			ST_VER, ST_TYPE: begin
				if (b != ((ps == ST_VER) ? reg_version : reg_type)) begin
					r.event_res = EV_HDR;
					clear_frame();
				end else begin
					p_crc = crc16_next(p_crc, b);
					ps = (ps == ST_VER) ? ST_TYPE : ST_SEQ_HI;
				end
			end
			ST_SEQ_HI: begin
				p_seq = {b, 8'h00};
				p_crc = crc16_next(p_crc, b);
				ps = ST_SEQ_LO;
			end
			ST_SEQ_LO: begin
				p_seq[7:0] = b;
				p_crc = crc16_next(p_crc, b);
				ps = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				p_len = {b, 8'h00};
				p_crc = crc16_next(p_crc, b);
				ps = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				p_len[7:0] = b;
				p_crc = crc16_next(p_crc, b);
				p_count = 16'h0000;
				if (p_len > MAX_LEN) begin
					r.event_res = EV_LEN;
					clear_frame();
				end else begin
					ps = (p_len != 16'h0000) ? ST_DATA : ST_CRC_HI;
				end
			end
			ST_DATA: begin
				r.payload_byte = b;
				r.payload_valid = 1'b1;
				if (p_count < IP_HDR_BYTES)
					p_head[p_count] = b;
				p_count = p_count + 16'd1;
				p_crc = crc16_next(p_crc, b);
				if (p_count >= p_len)
					ps = ST_CRC_HI;
			end
			ST_CRC_HI: begin
				p_crc_hi = b;
				ps = ST_CRC_LO;
			end
			ST_CRC_LO: begin
				if ({p_crc_hi, b} != p_crc) begin
					r.event_res = EV_CRC;
				end else begin
					iplen = ip_len_of();
					if (iplen == 0) begin
						r.event_res = EV_IP;
					end else if (full) begin
						r.event_res = EV_DROP;
					end else begin
						r.event_res = EV_OK;
						r.ip_length = iplen[11:0];
						if (acc_seq_valid) begin
							seq_delta = p_seq - (acc_seq_last + 16'd1);
							if (seq_delta < SEQ_HALF)
								r.seq_gap = seq_delta[14:0];
							else
								r.seq_reorder = 1'b1;
						end
						acc_seq_last = p_seq;
						acc_seq_valid = 1'b1;
					end
				end
				clear_frame();
			end
			default: clear_frame();
		endcase
		if (r.event_res != EV_NONE)
			r.frame_seq = p_seq;
		if (ps == ST_HUNT0 || ps == ST_HUNT1 || ps == ST_HUNT2)
			p_seq = 16'h0000;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 100)
			$display("mismatch at word %0d: %s", n_checked, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] exp);
		if (got !== exp)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, exp));
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_words.push_back(parse_rx_byte(rx_byte, queue_full));
			if (!in_valid || !in_stall) begin
				if (rx_backlog.size() > 0 && !send_pause && (calm || $urandom_range(99) >= 11)) begin
					drv_word = rx_backlog.pop_front();
					in_valid <= 1'b1;
					rx_byte <= drv_word.data;
					queue_full <= drv_word.full;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen = '{payload_byte, payload_valid, event_res, frame_seq, ip_length,
					seq_gap, seq_reorder};
				if (expected_words.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = expected_words.pop_front();
					check_field("payload_byte", seen.payload_byte, want.payload_byte);
					check_field("payload_valid", seen.payload_valid, want.payload_valid);
					check_field("event_res", seen.event_res, want.event_res);
					check_field("frame_seq", seen.frame_seq, want.frame_seq);
					check_field("ip_length", seen.ip_length, want.ip_length);
					check_field("seq_gap", seen.seq_gap, want.seq_gap);
					check_field("seq_reorder", seen.seq_reorder, want.seq_reorder);
				end
				n_checked++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 11);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic rand_full();
		return $urandom_range(7) == 0;
	endfunction

	task automatic put_byte(input logic [7:0] b, input logic full);
		rx_backlog.push_back('{b, full});
		made++;
	endtask

	task automatic put_hashed(inout logic [15:0] crc, input logic [7:0] b);
		crc = crc16_next(crc, b);
		put_byte(b, rand_full());
	endtask

	task automatic send_frame(input logic [7:0] ver, input logic [7:0] typ,
			input logic [15:0] seq, input logic [15:0] len, input byte_q_t head,
			input logic bad_crc, input logic full_end);
		logic [15:0] crc;
		logic [7:0] d;
		put_byte(SYNC0, rand_full());
		put_byte(SYNC1, rand_full());
		put_byte(SYNC2, rand_full());
		crc = CRC_SEED;
		put_hashed(crc, ver);
		put_hashed(crc, typ);
		put_hashed(crc, seq[15:8]);
		put_hashed(crc, seq[7:0]);
		put_hashed(crc, len[15:8]);
		put_hashed(crc, len[7:0]);
		if (len > MAX_LEN)
			return;
		for (int i = 0; i < len; i++) begin
			d = (i < head.size()) ? head[i] : 8'($urandom);
			put_hashed(crc, d);
		end
		if (bad_crc)
			crc = crc ^ (16'd1 << $urandom_range(15));
		put_byte(crc[15:8], rand_full());
		put_byte(crc[7:0], full_end);
	endtask

	task automatic make_head(input head_kind_t kind, input logic [15:0] len, output byte_q_t head);
		byte_q_t h;
		int unsigned ihl, hl, total, pl, top;
		repeat (IP_HDR_BYTES)
			h.push_back(8'($urandom));
		case (kind)
			HD_V4_OK: begin
				top = len / 4;
				if (top > 15)
					top = 15;
				if (top < 5)
					top = 5;
				ihl = $urandom_range(top, 5);
				hl = ihl * 4;
				total = $urandom_range((len >= hl) ? len : hl, hl);
				h[0] = {4'h4, 4'(ihl)};
				h[2] = 8'(total >> 8);
				h[3] = 8'(total);
			end
			HD_V4_BAD: begin
				case ($urandom_range(2))
					0: begin
						ihl = $urandom_range(4);
						total = len;
					end
					1: begin
						ihl = 5;
						total = $urandom_range(19);
					end
					default: begin
						ihl = $urandom_range(15, 5);
						total = len + $urandom_range(100, 1);
					end
				endcase
				h[0] = {4'h4, 4'(ihl)};
				h[2] = 8'(total >> 8);
				h[3] = 8'(total);
			end
			HD_V6_OK: begin
				pl = (len >= IPV6_HDR) ? $urandom_range(len - IPV6_HDR) : 0;
				h[0] = {4'h6, 4'($urandom)};
				h[4] = 8'(pl >> 8);
				h[5] = 8'(pl);
			end
			HD_V6_BAD: begin
				pl = $urandom_range(1) ? 16'hFFFF : (len - IPV6_HDR + $urandom_range(50, 1));
				h[0] = {4'h6, 4'($urandom)};
				h[4] = 8'(pl >> 8);
				h[5] = 8'(pl);
			end
			default: ;
		endcase
		head = h;
	endtask

	task automatic rand_frame();
		int unsigned pick, k;
		logic [15:0] len;
		logic [7:0] v, t, b;
		head_kind_t kind;
		byte_q_t h;
		pick = $urandom_range(99);
		v = reg_version;
		t = reg_type;
		case ($urandom_range(9))
			0: tx_seq = tx_seq + 16'($urandom_range(40, 2));
			1: tx_seq = tx_seq - 16'($urandom_range(40, 1));
			2: tx_seq = 16'($urandom);
			default: tx_seq = tx_seq + 16'd1;
		endcase
		if (pick < 8) begin
			repeat ($urandom_range(6, 1))
				put_byte($urandom_range(1) ? SYNC0 : 8'($urandom), rand_full());
		end else if (pick < 14) begin
			put_byte(SYNC0, rand_full());
			b = 8'($urandom);
			if ($urandom_range(1)) begin
				put_byte(SYNC1, rand_full());
				if (b == SYNC2)
					b = 8'h00;
			end else if (b == SYNC1) begin
				b = 8'hFF;
			end
			put_byte(b, rand_full());
		end else begin
			k = $urandom_range(99);
			if (k < 45) begin
				kind = HD_V4_OK;
				len = $urandom_range(48, 20);
			end else if (k < 70) begin
				kind = HD_V6_OK;
				len = $urandom_range(64, 40);
			end else if (k < 78) begin
				kind = HD_V4_BAD;
				len = $urandom_range(40, 20);
			end else if (k < 86) begin
				kind = HD_V6_BAD;
				len = $urandom_range(50, 40);
			end else if (k < 94) begin
				kind = HD_JUNK;
				len = $urandom_range(30);
			end else begin
				kind = HD_V4_OK;
				len = $urandom_range(19);
			end
			if (pick < 20) begin
				if ($urandom_range(1))
					v = v ^ 8'($urandom_range(255, 1));
				else
					t = t ^ 8'($urandom_range(255, 1));
			end else if (pick < 26) begin
				len = $urandom_range(65535, MAX_LEN + 1);
			end
			make_head(kind, len, h);
			send_frame(v, t, tx_seq, len, h, pick >= 26 && pick < 34, $urandom_range(99) < 15);
		end
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (rx_backlog.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_VERSION)
			reg_version = val;
		else
			reg_type = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic directed();
		byte_q_t h;
		put_byte(8'h00, 1'b0);
		put_byte(8'hFF, 1'b1);
		// sync hunt corner cases
		put_byte(SYNC0, 1'b0);
		put_byte(SYNC0, 1'b0);
		put_byte(SYNC1, 1'b0);
		put_byte(8'h3C, 1'b0);
		put_byte(SYNC0, 1'b0);
		put_byte(SYNC1, 1'b0);
		put_byte(SYNC0, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(SYNC0, 1'b0);
		put_byte(8'h00, 1'b0);
		make_head(HD_V4_OK, 20, h);
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0000, 20, h, 1'b0, 1'b0);
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0005, 20, h, 1'b0, 1'b0);
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0003, 20, h, 1'b0, 1'b0);
		send_frame(DEF_VERSION, DEF_TYPE, 16'hFFFF, 20, h, 1'b0, 1'b0);
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0000, 20, h, 1'b0, 1'b0);
		send_frame(DEF_VERSION, DEF_TYPE, 16'h8000, 20, h, 1'b0, 1'b0);
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0001, 20, h, 1'b0, 1'b0);
		send_frame(8'h02, DEF_TYPE, 16'h0002, 20, h, 1'b0, 1'b0);
		send_frame(DEF_VERSION, 8'hFE, 16'h0002, 20, h, 1'b0, 1'b0);
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0002, 0, h, 1'b0, 1'b0);
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0002, 20, h, 1'b1, 1'b0);
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0002, 20, h, 1'b0, 1'b1);
		send_frame(DEF_VERSION, DEF_TYPE, 16'h1234, MAX_LEN + 1, h, 1'b0, 1'b0);
		send_frame(DEF_VERSION, DEF_TYPE, 16'hABCD, 16'hFFFF, h, 1'b0, 1'b0);
		make_head(HD_V6_OK, 40, h);
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0002, 40, h, 1'b0, 1'b0);
		make_head(HD_V6_BAD, 40, h);
		h[4] = 8'hFF;
		h[5] = 8'hFF;
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0003, 40, h, 1'b0, 1'b0);
		make_head(HD_V4_OK, 60, h);
		h[0] = 8'h4F;
		h[2] = 8'h00;
		h[3] = 8'd60;
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0004, 60, h, 1'b0, 1'b0);
		make_head(HD_V4_BAD, 20, h);
		h[0] = 8'h44;
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0005, 20, h, 1'b0, 1'b0);
		make_head(HD_JUNK, 20, h);
		h[0] = 8'h55;
		send_frame(DEF_VERSION, DEF_TYPE, 16'h0006, 20, h, 1'b0, 1'b0);
		tx_seq = 16'h0006;
	endtask

	initial begin
		logic [7:0] v, t;
		int unsigned target;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		calm = 1'b1;
		directed();
		for (int p = 0; p < 4; p++) begin
			settle();
			case (p)
				0: begin
					v = 8'hFF;
					t = 8'h00;
				end
				1: begin
					v = 8'h00;
					t = 8'hFF;
				end
				2: begin
					v = 8'($urandom);
					t = 8'($urandom);
				end
				default: begin
					v = DEF_VERSION;
					t = DEF_TYPE;
				end
			endcase
			write_reg(REG_VERSION, v);
			write_reg(REG_TYPE, t);
			@(negedge clk);
			calm = (p == 3);
			target = made + 10;
			while (made < target)
				rand_frame();
			if (p == 1)
				hold_req = 1'b1;
			if (p == 2) begin
				while (rx_backlog.size() > 4)
					@(negedge clk);
				send_pause = 1'b1;
				do
					@(negedge clk);
				while (in_valid || expected_words.size() != 0);
				send_pause = 1'b0;
			end
		end
		settle();
		calm = 1'b0;
		repeat (4) @(posedge clk);
		if (expected_words.size() != 0)
			report_mismatch($sformatf("%0d expected words never arrived", expected_words.size()));
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
